### rtl/pprs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pprs_pkg;
  localparam int QueueDepth = 8;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam int IdxW = $clog2(QueueDepth);
  localparam logic [15:0] QuantumReset = 16'd10;

  localparam logic ModeArrive = 1'b0;
  localparam logic ModeTick   = 1'b1;
  localparam logic StatDone   = 1'b0;
  localparam logic StatDrop   = 1'b1;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [15:0] remain;
    logic [15:0] arrival;
  } task_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] turnaround;
    logic [15:0] wait_span;
    logic        status;
  } result_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load_in;     // capture input word
    logic do_arrive;   // insert captured task or drop
    logic do_pick;     // idle pick of head
    logic do_preempt;  // higher-prio preemption
    logic do_rr;       // quantum yield
    logic do_run;      // one unit of work, advance time
  } cmd_t;

  typedef struct packed {
    logic    has_result;
    result_t res;
  } stat_t;
endpackage
`default_nettype wire

### rtl/preemptive_priority_rr_scheduler.sv
// Preemptive priority scheduler, round robin among equal priorities.
// Input stream s_axis: tuser = mode (0 arrive, 1 tick); tdata = task_id,
// priority_req, burst. Output stream m_axis: tuser = status (0 done,
// 1 dropped); tdata = done_id, turnaround, wait.
// Config channel cfg_valid_i/cfg_ready_o/cfg_data_i writes the quantum;
// write only while idle.
// One word at a time: an arrival runs an arrive step, a tick the pick,
// preempt, yield and run steps of the controller, each step one
// compare-and-shift of the register queue. A result is registered in
// the datapath, then flagged pending by the controller; it shows on
// m_axis and holds until taken; no new word is accepted while a result waits.
// Reset clears queue count, running task, time; quantum returns to 10.
`timescale 1ns / 1ps
`default_nettype none
module preemptive_priority_rr_scheduler import pprs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // task_id, priority_req, burst
  input  wire logic        s_axis_tuser,   // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // done_id, turnaround, wait
  output logic             m_axis_tuser,   // status
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);
  cmd_t        cmd;
  stat_t       stat;
  logic [15:0] quantum_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) quantum_q <= QuantumReset;
    else if (cfg_valid_i) quantum_q <= cfg_data_i;
  end

  pprs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_mode_i(s_axis_tuser), .in_ready_o(s_axis_tready),
    .stat_i(stat), .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd)
  );

  pprs_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .id_i(s_axis_tdata[7:0]), .prio_i(s_axis_tdata[15:8]), .burst_i(s_axis_tdata[31:16]),
    .quantum_i(quantum_q), .stat_o(stat)
  );

  assign m_axis_tdata = {stat.res.wait_span, stat.res.turnaround, stat.res.id};
  assign m_axis_tuser = stat.res.status;
endmodule
`default_nettype wire

### rtl/pprs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module pprs_datapath import pprs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  input  wire logic [7:0]  id_i,
  input  wire logic [7:0]  prio_i,
  input  wire logic [15:0] burst_i,
  input  wire logic [15:0] quantum_i,
  output stat_t            stat_o
);
  task_t            q_q [QueueDepth];
  logic [CntW-1:0]  cnt_q;
  logic             run_v_q;
  task_t            run_q;
  logic [15:0]      slice_q, time_q;
  task_t            in_q;

  logic             full, nonempty;
  logic [QueueDepth-1:0] ins_ge;
  task_t            ins_t;
  logic             do_ins, do_pop;

  assign full = cnt_q >= CntW'(QueueDepth);
  assign nonempty = cnt_q != '0;

  // choose what goes into the queue this step
  always_comb begin
    ins_t  = in_q;
    do_ins = 1'b0;
    do_pop = 1'b0;
    if (cmd_i.do_arrive) begin
      do_ins = !full;
    end else if (cmd_i.do_pick) begin
      do_pop = run_v_q ? 1'b0 : nonempty;
    end else if (cmd_i.do_preempt) begin
      if (run_v_q && nonempty && q_q[0].prio > run_q.prio) begin
        do_pop = 1'b1; do_ins = 1'b1; ins_t = run_q;
      end
    end else if (cmd_i.do_rr) begin
      if (run_v_q && nonempty && slice_q >= quantum_i && q_q[0].prio == run_q.prio) begin
        do_pop = 1'b1; do_ins = 1'b1; ins_t = run_q;
      end
    end else if (cmd_i.do_run) begin
      do_pop = run_v_q && run_q.remain <= 16'd1 && nonempty;
    end
  end

  // position: first slot whose entry is below the new priority
  always_comb begin
    for (int i = 0; i < QueueDepth; i++)
      ins_ge[i] = (CntW'(i) < cnt_q) && (q_q[i].prio >= ins_t.prio);
  end

  // shift-register queue: pop shifts down, insert shifts up at position
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QueueDepth; i++) begin
      task_t src, up, cur;
      logic  ge_i, ge_p;
      cur  = q_q[i];
      src  = (i + 1 < QueueDepth) ? q_q[(i + 1) % QueueDepth] : q_q[i];
      ge_i = (i + 1 < QueueDepth) ? ins_ge[(i + 1) % QueueDepth] : 1'b0;
      up   = (i > 0) ? q_q[(i + QueueDepth - 1) % QueueDepth] : q_q[i];
      ge_p = (i > 0) ? ins_ge[(i + QueueDepth - 1) % QueueDepth] : 1'b1;
      if (do_pop && do_ins) begin
        // after removing head, slot i holds old i+1 unless insert goes here
        if (!ge_i) begin
          if (i == 0 || ins_ge[i]) q_q[i] <= ins_t;
          else q_q[i] <= cur;
        end else q_q[i] <= src;
      end else if (do_pop) begin
        q_q[i] <= src;
      end else if (do_ins) begin
        if (!ins_ge[i]) begin
          if (ge_p) q_q[i] <= ins_t;
          else q_q[i] <= up;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      run_v_q <= 1'b0;
      run_q   <= '0;
      slice_q <= '0;
      time_q  <= '0;
      stat_o  <= '0;
    end else begin
      if (cmd_i.load_in) stat_o.has_result <= 1'b0;
      if (do_ins && !do_pop) cnt_q <= cnt_q + CntW'(1);
      if (do_pop && !do_ins) cnt_q <= cnt_q - CntW'(1);
      if (cmd_i.do_arrive && full) begin
        stat_o.has_result     <= 1'b1;
        stat_o.res.status     <= StatDrop;
        stat_o.res.id         <= in_q.id;
        stat_o.res.turnaround <= '0;
        stat_o.res.wait_span  <= '0;
      end
      if (cmd_i.do_pick && do_pop) begin
        run_q <= q_q[0]; slice_q <= '0; run_v_q <= 1'b1;
      end
      if ((cmd_i.do_preempt || cmd_i.do_rr) && do_pop) begin
        run_q <= q_q[0]; slice_q <= '0;
      end
      if (cmd_i.do_run) begin
        time_q <= time_q + 16'd1;
        if (run_v_q) begin
          if (run_q.remain <= 16'd1) begin
            stat_o.has_result     <= 1'b1;
            stat_o.res.status     <= StatDone;
            stat_o.res.id         <= run_q.id;
            stat_o.res.turnaround <= time_q + 16'd1 - run_q.arrival;
            stat_o.res.wait_span  <= time_q + 16'd1 - run_q.arrival - run_q.burst;
            slice_q <= '0;
            if (nonempty) run_q <= q_q[0];
            else begin
              run_v_q <= 1'b0; run_q <= '0;
            end
          end else begin
            run_q.remain <= run_q.remain - 16'd1;
            if (slice_q != 16'hFFFF) slice_q <= slice_q + 16'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q.id      <= id_i;
      in_q.prio    <= prio_i;
      in_q.burst   <= burst_i;
      in_q.remain  <= burst_i;
      in_q.arrival <= time_q;
    end
  end
endmodule
`default_nettype wire

### rtl/pprs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pprs_ctrl import pprs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  in_mode_i,
  output logic       in_ready_o,
  input  wire stat_t stat_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output cmd_t       cmd_o
);
  typedef enum logic [5:0] {
    StIdle    = 6'b000001,
    StArrive  = 6'b000010,
    StPick    = 6'b000100,
    StPreempt = 6'b001000,
    StRr      = 6'b010000,
    StRun     = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic   fresh_q;

  // hold off input for the cycle in which a new result is latched
  assign in_ready_o  = (state_q == StIdle) && !pend_q && !fresh_q;
  assign out_valid_o = pend_q;

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    cmd_o   = '0;
    if (pend_q && out_ready_i) pend_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load_in = 1'b1;
          state_d = (in_mode_i == ModeTick) ? StPick : StArrive;
        end
      end
      StArrive: begin
        cmd_o.do_arrive = 1'b1; state_d = StIdle;
      end
      StPick:    begin cmd_o.do_pick = 1'b1;    state_d = StPreempt; end
      StPreempt: begin cmd_o.do_preempt = 1'b1; state_d = StRr;      end
      StRr:      begin cmd_o.do_rr = 1'b1;      state_d = StRun;     end
      StRun: begin
        cmd_o.do_run = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    // result is flagged pending in the cycle after the step that made it
    if (state_q == StIdle && stat_i.has_result && !pend_q && cmd_o.load_in == 1'b0
        && fresh_q) pend_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pend_q  <= 1'b0;
      fresh_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      fresh_q <= (state_q == StArrive) || (state_q == StRun);
    end
  end
endmodule
`default_nettype wire

### rtl/pprs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module pprs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic        m_axis_tuser,
  input wire logic [39:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[39:8] == 32'd0)
    else $error("drop word carries times");
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result waits");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("back to back accept");
endmodule
bind preemptive_priority_rr_scheduler pprs_checker u_chk (.*);
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import pprs_pkg::*;

  typedef struct {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [15:0] remain;
    logic [15:0] arrival;
  } job_t;

  typedef struct {
    logic        status;
    logic [7:0]  id;
    logic [15:0] tat;
    logic [15:0] wt;
  } report_t;

  // directed row: mode, id, prio, burst, with an optional typed expectation
  typedef struct {
    logic        mode;
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] burst;
    bit          typed;
    report_t     want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  preemptive_priority_rr_scheduler dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // scheduler mirror
  logic [15:0] quantum_q;
  job_t        ready_q[$];
  bit          run_valid;
  job_t        run_job;
  logic [15:0] run_slice;
  logic [15:0] now_q;
  report_t     pending_reports[$];
  int          mismatches = 0;
  bit          quiet = 1'b0;
  bit          row_typed = 1'b0;
  report_t     row_want;

  function automatic void enqueue_job(job_t j);
    int pos = 0;
    while (pos < ready_q.size() && ready_q[pos].prio >= j.prio) pos++;
    ready_q.insert(pos, j);
  endfunction

  function automatic void switch_head();
    job_t old = run_job;
    run_job = ready_q.pop_front();
    run_slice = '0;
    enqueue_job(old);
  endfunction

  function automatic void schedule_word(logic mode, logic [7:0] id, logic [7:0] prio,
                                        logic [15:0] burst);
    job_t j;
    report_t r;
    if (mode == ModeArrive) begin
      j.id = id; j.prio = prio; j.burst = burst; j.remain = burst; j.arrival = now_q;
      if (ready_q.size() >= QueueDepth) begin
        r.status = StatDrop; r.id = id; r.tat = '0; r.wt = '0;
        pending_reports.push_back(r);
      end else begin
        enqueue_job(j);
      end
      return;
    end
    if (!run_valid && ready_q.size() > 0) begin
      run_job = ready_q.pop_front();
      run_slice = '0;
      run_valid = 1'b1;
    end
    if (run_valid && ready_q.size() > 0 && ready_q[0].prio > run_job.prio) switch_head();
    if (run_valid && ready_q.size() > 0 && run_slice >= quantum_q &&
        ready_q[0].prio == run_job.prio) switch_head();
    now_q = now_q + 16'd1;
    if (!run_valid) return;
    if (run_slice != 16'hFFFF) run_slice++;
    if (run_job.remain <= 16'd1) begin
      r.status = StatDone;
      r.id = run_job.id;
      r.tat = now_q - run_job.arrival;
      r.wt = r.tat - run_job.burst;
      pending_reports.push_back(r);
      run_slice = '0;
      if (ready_q.size() > 0) run_job = ready_q.pop_front();
      else run_valid = 1'b0;
    end else begin
      run_job.remain--;
    end
  endfunction

  function automatic void flag_mismatch(string what, report_t w, logic [39:0] d, logic u);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: want st=%0d id=%0d tat=%0d wt=%0d, got st=%0d id=%0d tat=%0d wt=%0d",
               what, w.status, w.id, w.tat, w.wt, u, d[7:0], d[23:8], d[39:24]);
  endfunction

  // check result words
  always @(posedge clk_i) begin
    report_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        w = '{default: '0};
        flag_mismatch("unexpected", w, m_axis_tdata, m_axis_tuser);
      end else begin
        w = pending_reports.pop_front();
        if (m_axis_tuser !== w.status || m_axis_tdata[7:0] !== w.id ||
            m_axis_tdata[23:8] !== w.tat || m_axis_tdata[39:24] !== w.wt)
          flag_mismatch("field", w, m_axis_tdata, m_axis_tuser);
        else if (row_typed && (w.status !== row_want.status || w.id !== row_want.id ||
                 w.tat !== row_want.tat || w.wt !== row_want.wt))
          flag_mismatch("table", row_want, m_axis_tdata, m_axis_tuser);
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 25);
  end

  task automatic send_word(logic mode, logic [7:0] id, logic [7:0] prio, logic [15:0] burst);
    while (!quiet && $urandom_range(0, 99) < 25) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {burst, prio, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    schedule_word(mode, id, prio, burst);
    s_axis_tvalid <= 1'b0;
    // the block cannot take another word while it works through the steps of this one anyway
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_quantum(logic [15:0] q);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= q;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    quantum_q = q;
  endtask

  task automatic random_phase(int n, int max_burst);
    logic [7:0] id;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 30) begin
        id = 8'($urandom);
        send_word(ModeArrive, id,
                  8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)),
                  16'($urandom_range(0, 19) == 0 ? $urandom : $urandom_range(0, max_burst)));
      end else begin
        send_word(ModeTick, 8'($urandom), 8'($urandom), 16'($urandom));
      end
    end
  endtask

  row_t table_rows[$];

  initial begin
    row_t r;
    quantum_q = QuantumReset;
    run_valid = 1'b0;
    run_job = '{default: '0};
    run_slice = '0;
    now_q = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle tick, zero burst, extremes, then fill past depth to force a drop
    table_rows.push_back('{ModeTick, 8'h00, 8'h00, 16'h0000, 1'b0, '{default: '0}});
    table_rows.push_back('{ModeArrive, 8'hFF, 8'hFF, 16'h0000, 1'b0, '{default: '0}});
    table_rows.push_back('{ModeTick, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, '{StatDone, 8'hFF, 16'd1, 16'd1}});
    table_rows.push_back('{ModeArrive, 8'h01, 8'h00, 16'h0001, 1'b0, '{default: '0}});
    table_rows.push_back('{ModeTick, 8'h00, 8'h00, 16'h0000, 1'b1, '{StatDone, 8'h01, 16'd1, 16'd0}});
    for (int i = 0; i < 8; i++)
      table_rows.push_back('{ModeArrive, 8'(16 + i), 8'(i % 3), 16'(3 + i), 1'b0, '{default: '0}});
    table_rows.push_back('{ModeArrive, 8'hAA, 8'h55, 16'hFFFF, 1'b1, '{StatDrop, 8'hAA, 16'd0, 16'd0}});
    table_rows.push_back('{ModeArrive, 8'h55, 8'hAA, 16'h8000, 1'b1, '{StatDrop, 8'h55, 16'd0, 16'd0}});
    table_rows.push_back('{ModeTick, 8'h00, 8'h00, 16'h0000, 1'b0, '{default: '0}});
    table_rows.push_back('{ModeArrive, 8'h77, 8'hFE, 16'h0002, 1'b0, '{default: '0}});
    for (int i = 0; i < 6; i++)
      table_rows.push_back('{ModeTick, 8'h00, 8'h00, 16'h0000, 1'b0, '{default: '0}});
    foreach (table_rows[i]) begin
      r = table_rows[i];
      row_typed = r.typed;
      row_want = r.want;
      send_word(r.mode, r.id, r.prio, r.burst);
      if (r.typed) drain();
      row_typed = 1'b0;
    end

    // flush leftover work so later phases start clean
    while (run_valid || ready_q.size() != 0) send_word(ModeTick, '0, '0, '0);
    write_quantum(16'd1);
    random_phase(300, 12);
    quiet = 1'b1;
    random_phase(100, 12);
    quiet = 1'b0;
    write_quantum(16'd0);
    random_phase(250, 8);
    write_quantum(16'hFFFF);
    random_phase(250, 10);
    write_quantum(16'd3);
    random_phase(300, 15);
    write_quantum(16'h5AA5);
    random_phase(200, 10);
    drain();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
`default_nettype wire
